// ===== hdl/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

  localparam int unsigned NumSlotsDef = 32;
  localparam int unsigned SizeBitsDef = 16;

  localparam int unsigned FuncW     = 2;
  localparam int unsigned InSizeW   = 16;
  localparam int unsigned SelW      = 5;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned OutIdxW   = 5;
  localparam int unsigned OutSizeW  = 16;
  localparam int unsigned OwnerW    = 8;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 32;

  localparam logic [OwnerW-1:0] OwnerMax = '1;

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_ALLOC = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FIT   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_UNLOADED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

  // Broadcast commands from the controller to every cell.
  typedef struct packed {
    logic clear;
    logic load;
    logic grant;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/bfa_cell.sv =====
`default_nettype none

module bfa_cell #(
  parameter int unsigned NUM_SLOTS = bfa_pkg::NumSlotsDef,
  parameter int unsigned SIZE_BITS = bfa_pkg::SizeBitsDef,
  parameter int unsigned CELL_IDX  = 0,
  localparam int unsigned IdxW     = $clog2(NUM_SLOTS)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire bfa_pkg::cell_ctrl_t     ctrl_i,
  input  wire  [IdxW-1:0]              wr_idx_i,
  input  wire  [SIZE_BITS-1:0]         wr_size_i,
  input  wire  [bfa_pkg::OwnerW-1:0]   owner_i,
  input  wire  [SIZE_BITS-1:0]         req_size_i,
  input  wire bfa_pkg::tok_t           tok_i,
  input  wire  [SIZE_BITS-1:0]         best_size_i,
  input  wire  [IdxW-1:0]              best_idx_i,
  output bfa_pkg::tok_t                tok_o,
  output logic [SIZE_BITS-1:0]         best_size_o,
  output logic [IdxW-1:0]              best_idx_o,
  output logic [SIZE_BITS-1:0]         size_o,
  output logic                         used_o,
  output logic [bfa_pkg::OwnerW-1:0]   owner_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);

  logic                        loaded_q;
  logic                        used_q;
  logic [SIZE_BITS-1:0]        size_q;
  logic [bfa_pkg::OwnerW-1:0]  owner_q;
  bfa_pkg::tok_t               tok_q;
  logic [SIZE_BITS-1:0]        best_size_q;
  logic [IdxW-1:0]             best_idx_q;
  logic                        hit_wr;
  logic                        take;

  assign hit_wr = (wr_idx_i == MyIdx);
  assign take   = loaded_q && !used_q && (size_q >= req_size_i) &&
                  (!tok_i.found || (size_q < best_size_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      used_q   <= 1'b0;
      tok_q    <= '0;
    end else begin
      tok_q.valid <= tok_i.valid;
      tok_q.found <= tok_i.found || take;
      if (ctrl_i.clear) begin
        loaded_q <= 1'b0;
        used_q   <= 1'b0;
      end else if (ctrl_i.load && hit_wr) begin
        loaded_q <= 1'b1;
        used_q   <= 1'b0;
      end else if (ctrl_i.grant && hit_wr) begin
        used_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_size_q <= take ? size_q : best_size_i;
    best_idx_q  <= take ? MyIdx : best_idx_i;
    if (ctrl_i.load && hit_wr) begin
      size_q <= wr_size_i;
    end
    if (ctrl_i.grant && hit_wr) begin
      owner_q <= owner_i;
    end
  end

  assign tok_o       = tok_q;
  assign best_size_o = best_size_q;
  assign best_idx_o  = best_idx_q;
  assign size_o      = size_q;
  assign used_o      = used_q;
  assign owner_o     = owner_q;

endmodule

`default_nettype wire

// ===== hdl/best_fit_block_allocator_core.sv =====
`default_nettype none

// Best-fit block allocator. Each slot of the table lives in one cell of a chain; words on the
// input stream clear the table, load the next block size, request an allocation or read one
// slot, and every input word yields exactly one result word. An allocation walks a search token
// through the chain, one cell per cycle, carrying the smallest fitting free size seen so far.
// Only one word is in progress at a time, and a finished result waits in the output register.
module best_fit_block_allocator_core #(
  parameter int unsigned NUM_SLOTS = bfa_pkg::NumSlotsDef,
  parameter int unsigned SIZE_BITS = bfa_pkg::SizeBitsDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // size_value [15:0], slot_select [20:16], zero [23:21]
  input  wire  [bfa_pkg::InDataW-1:0]    s_axis_tdata_i,
  // func [1:0]
  input  wire  [bfa_pkg::FuncW-1:0]      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  // slot_index [4:0], block_size_out [20:5], slot_used [21], owner_request [29:22], zero [31:30]
  output logic [bfa_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // status [1:0]
  output logic [bfa_pkg::StatusW-1:0]    m_axis_tuser_o
);

  localparam int unsigned IdxW = $clog2(NUM_SLOTS);
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(NUM_SLOTS);

  bfa_pkg::state_e             state_q, state_d;
  logic [CntW-1:0]             slot_count_q, slot_count_d;
  logic [bfa_pkg::OwnerW-1:0]  req_count_q, req_count_d;
  logic [bfa_pkg::OwnerW-1:0]  seq_q, seq_d;
  logic [SIZE_BITS-1:0]        req_size_q, req_size_d;
  logic                        start_q, start_d;

  bfa_pkg::status_e            res_status_q, res_status_d;
  logic [bfa_pkg::OutIdxW-1:0] res_idx_q, res_idx_d;
  logic [bfa_pkg::OutSizeW-1:0] res_size_q, res_size_d;
  logic                        res_used_q, res_used_d;
  logic [bfa_pkg::OwnerW-1:0]  res_owner_q, res_owner_d;

  logic                        m_valid_q, m_valid_d;
  logic [bfa_pkg::OutDataW-1:0] m_data_q;
  logic [bfa_pkg::StatusW-1:0] m_user_q;
  logic                        out_load;

  logic                        in_acc;
  bfa_pkg::func_e              in_func;
  logic [bfa_pkg::InSizeW-1:0] in_size;
  logic [bfa_pkg::SelW-1:0]    in_sel;
  logic [SIZE_BITS+bfa_pkg::InSizeW-1:0] in_size_ext;
  logic [SIZE_BITS-1:0]        in_size_m;
  logic [CntW+bfa_pkg::SelW-1:0] sel_ext;
  logic [IdxW-1:0]             rd_idx;
  logic                        sel_loaded;

  bfa_pkg::cell_ctrl_t         ctrl;
  logic [IdxW-1:0]             wr_idx;

  bfa_pkg::tok_t               chain_tok  [NUM_SLOTS+1];
  logic [SIZE_BITS-1:0]        chain_size [NUM_SLOTS+1];
  logic [IdxW-1:0]             chain_idx  [NUM_SLOTS+1];
  logic [SIZE_BITS-1:0]        cell_size  [NUM_SLOTS];
  logic                        cell_used  [NUM_SLOTS];
  logic [bfa_pkg::OwnerW-1:0]  cell_owner [NUM_SLOTS];

  function automatic logic [bfa_pkg::OutSizeW-1:0] to_out_size(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS+bfa_pkg::OutSizeW-1:0] w;
    w = {{bfa_pkg::OutSizeW{1'b0}}, v};
    return w[bfa_pkg::OutSizeW-1:0];
  endfunction

  function automatic logic [bfa_pkg::OutIdxW-1:0] to_out_idx(input logic [IdxW-1:0] v);
    logic [IdxW+bfa_pkg::OutIdxW-1:0] w;
    w = {{bfa_pkg::OutIdxW{1'b0}}, v};
    return w[bfa_pkg::OutIdxW-1:0];
  endfunction

  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign in_func     = bfa_pkg::func_e'(s_axis_tuser_i);
  assign in_size     = s_axis_tdata_i[15:0];
  assign in_sel      = s_axis_tdata_i[20:16];
  assign in_size_ext = {{SIZE_BITS{1'b0}}, in_size};
  assign in_size_m   = in_size_ext[SIZE_BITS-1:0];
  assign sel_ext     = {{CntW{1'b0}}, in_sel};
  assign rd_idx      = sel_ext[IdxW-1:0];
  assign sel_loaded  = sel_ext < {{bfa_pkg::SelW{1'b0}}, slot_count_q};
  assign wr_idx      = slot_count_q[IdxW-1:0];

  assign chain_tok[0]  = '{valid: start_q, found: 1'b0};
  assign chain_size[0] = '0;
  assign chain_idx[0]  = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    bfa_cell #(
      .NUM_SLOTS (NUM_SLOTS),
      .SIZE_BITS (SIZE_BITS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .wr_idx_i    (state_q == bfa_pkg::ST_SCAN ? chain_idx[NUM_SLOTS] : wr_idx),
      .wr_size_i   (in_size_m),
      .owner_i     (seq_q),
      .req_size_i  (req_size_q),
      .tok_i       (chain_tok[g]),
      .best_size_i (chain_size[g]),
      .best_idx_i  (chain_idx[g]),
      .tok_o       (chain_tok[g+1]),
      .best_size_o (chain_size[g+1]),
      .best_idx_o  (chain_idx[g+1]),
      .size_o      (cell_size[g]),
      .used_o      (cell_used[g]),
      .owner_o     (cell_owner[g])
    );
  end

  always_comb begin
    state_d      = state_q;
    slot_count_d = slot_count_q;
    req_count_d  = req_count_q;
    seq_d        = seq_q;
    req_size_d   = req_size_q;
    start_d      = 1'b0;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_size_d   = res_size_q;
    res_used_d   = res_used_q;
    res_owner_d  = res_owner_q;
    ctrl         = '0;
    out_load     = 1'b0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      bfa_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) begin
          res_status_d = bfa_pkg::STAT_OK;
          res_idx_d    = '0;
          res_size_d   = '0;
          res_used_d   = 1'b0;
          res_owner_d  = '0;
          state_d      = bfa_pkg::ST_DONE;
          unique case (in_func)
            bfa_pkg::FUNC_CLEAR: begin
              ctrl.clear   = 1'b1;
              slot_count_d = '0;
              req_count_d  = '0;
            end
            bfa_pkg::FUNC_LOAD: begin
              if (slot_count_q == CntFull) begin
                res_status_d = bfa_pkg::STAT_FULL;
              end else begin
                ctrl.load    = 1'b1;
                res_idx_d    = to_out_idx(wr_idx);
                res_size_d   = to_out_size(in_size_m);
                slot_count_d = slot_count_q + CntW'(1);
              end
            end
            bfa_pkg::FUNC_ALLOC: begin
              req_size_d = in_size_m;
              seq_d      = req_count_q;
              if (req_count_q != bfa_pkg::OwnerMax) begin
                req_count_d = req_count_q + bfa_pkg::OwnerW'(1);
              end
              start_d = 1'b1;
              state_d = bfa_pkg::ST_SCAN;
            end
            bfa_pkg::FUNC_READ: begin
              res_idx_d = in_sel;
              if (sel_loaded) begin
                res_size_d  = to_out_size(cell_size[rd_idx]);
                res_used_d  = cell_used[rd_idx];
                res_owner_d = cell_used[rd_idx] ? cell_owner[rd_idx] : '0;
              end else begin
                res_status_d = bfa_pkg::STAT_UNLOADED;
              end
            end
            default: ;
          endcase
        end
      end
      bfa_pkg::ST_SCAN: begin
        if (chain_tok[NUM_SLOTS].valid) begin
          state_d = bfa_pkg::ST_DONE;
          if (chain_tok[NUM_SLOTS].found) begin
            ctrl.grant   = 1'b1;
            res_status_d = bfa_pkg::STAT_OK;
            res_idx_d    = to_out_idx(chain_idx[NUM_SLOTS]);
            res_size_d   = to_out_size(chain_size[NUM_SLOTS]);
            res_used_d   = 1'b1;
            res_owner_d  = seq_q;
          end else begin
            res_status_d = bfa_pkg::STAT_NO_FIT;
            res_idx_d    = '0;
            res_size_d   = '0;
            res_used_d   = 1'b0;
            res_owner_d  = '0;
          end
        end
      end
      bfa_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = bfa_pkg::ST_IDLE;
        end
      end
      default: state_d = bfa_pkg::ST_IDLE;
    endcase
  end

  assign m_valid_d = out_load || (m_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bfa_pkg::ST_IDLE;
      slot_count_q <= '0;
      req_count_q  <= '0;
      start_q      <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_count_q <= slot_count_d;
      req_count_q  <= req_count_d;
      start_q      <= start_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q        <= seq_d;
    req_size_q   <= req_size_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_size_q   <= res_size_d;
    res_used_q   <= res_used_d;
    res_owner_q  <= res_owner_d;
    if (out_load) begin
      m_data_q <= {2'b00, res_owner_q, res_used_q, res_size_q, res_idx_q};
      m_user_q <= res_status_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_tok_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_tok[NUM_SLOTS].valid |-> state_q == bfa_pkg::ST_SCAN)
    else $error("Search token left the chain outside a scan.");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_count_q <= CntFull)
    else $error("Slot count exceeds the table size.");

  a_req_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && in_func == bfa_pkg::FUNC_CLEAR) |=> req_count_q >= $past(req_count_q))
    else $error("Request counter went down without a clear.");

  a_grant_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.grant |-> !cell_used[chain_idx[NUM_SLOTS]])
    else $error("Granted a slot that is already used.");

endmodule

`default_nettype wire
